### rtl/core/lvad_pkg.sv
// Shared constants and types for the ladder voltage address decoder.
// Holds field widths, conversion constants and the nominal voltage table.
// No dependencies.
package lvad_pkg;

  localparam int SAMPLE_W = 10;
  localparam int WIN_W    = 11;
  localparam int MV_W     = 12;
  localparam int ADDR_W   = 6;
  localparam int IDX_W    = 4;
  localparam int NUM_NOM  = 16;

  localparam logic [WIN_W-1:0]  WIN_RESET = 11'd75;
  localparam logic [ADDR_W-1:0] ADDR_BASE = 6'h30;
  localparam logic [MV_W-1:0]   MV_FULL   = 12'd3300;

  // Scaled count: avg * 3300 stays below 2**22.
  localparam int SCL_W = 22;
  // floor(x / 1023) == (x * ceil(2**32 / 1023)) >> 32 for every x below 2**22.
  localparam int                 MV_SHIFT = 32;
  localparam int                 RCP_W    = 23;
  localparam logic [RCP_W-1:0]   MV_RECIP = 23'd4198405;
  localparam logic [SCL_W-1:0]   SCL_MAX  = 22'd3375900;

  typedef logic [MV_W-1:0] mv_t;

  localparam mv_t NOMINAL_MV [NUM_NOM] = '{
    12'd3147, 12'd2944, 12'd2740, 12'd2548, 12'd2341, 12'd2135, 12'd1926, 12'd1734,
    12'd1535, 12'd1341, 12'd1137, 12'd933,  12'd738,  12'd541,  12'd342,  12'd153
  };

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] address;
    mv_t               millivolts;
  } result_t;

endpackage

### rtl/core/lvad_accum.sv
// Batch accumulator: sums incoming samples and hands off the batch total.
// Depends on lvad_pkg.
module lvad_accum #(
  parameter int SAMPLES = 16,
  parameter int SUM_W   = 14
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lvad_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                            tot_valid,
  input  logic                            tot_ready,
  output logic [SUM_W-1:0]                tot_sum
);
  import lvad_pkg::*;

  localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES - 1);
  localparam logic [SUM_W-1:0] SUM_MAX  = SUM_W'(1023 * SAMPLES);

  logic [SUM_W-1:0] sum_r, sum_nxt, total_r, total_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             tv_r, tv_nxt;
  logic             accept, last_word;

  assign in_ready  = !tv_r || tot_ready;
  assign accept    = in_valid && in_ready;
  assign last_word = (cnt_r == CNT_LAST);

  always_comb begin
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    total_nxt = total_r;
    tv_nxt    = tv_r && !tot_ready;
    if (accept) begin
      if (last_word) begin
        total_nxt = sum_r + SUM_W'(in_sample);
        tv_nxt    = 1'b1;
        sum_nxt   = '0;
        cnt_nxt   = '0;
      end else begin
        sum_nxt = sum_r + SUM_W'(in_sample);
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      tv_r  <= 1'b0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      tv_r  <= tv_nxt;
    end
    total_r <= total_nxt;
  end

  assign tot_valid = tv_r;
  assign tot_sum   = total_r;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_LAST) else $error("sample count out of range");
  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    tv_r |-> total_r <= SUM_MAX) else $error("batch total exceeds maximum");
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last_word) |=> (cnt_r == '0) && (sum_r == '0) && tv_r)
    else $error("accumulator did not restart after a batch");
`endif

endmodule

### rtl/core/lvad_convert.sv
// Converts a batch total into floored millivolts in three register stages.
// Both divisions are reciprocal multiplies. Depends on lvad_pkg.
module lvad_convert #(
  parameter int SAMPLES = 16,
  parameter int SUM_W   = 14
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      tot_valid,
  output logic                      tot_ready,
  input  logic [SUM_W-1:0]          tot_sum,
  output logic                      mv_valid,
  input  logic                      mv_ready,
  output lvad_pkg::mv_t             mv_value
);
  import lvad_pkg::*;

  // floor(sum / SAMPLES) == (sum * ceil(2**DIV_K / SAMPLES)) >> DIV_K, exact for all sums.
  localparam int DIV_K = SUM_W + 9;
  localparam longint unsigned DIV_M_L =
    ((64'd1 << DIV_K) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);
  localparam logic [DIV_K:0] DIV_M = DIV_M_L[DIV_K:0];
  localparam int PROD_W = SUM_W + DIV_K + 1;
  localparam int MVP_W  = SCL_W + RCP_W;

  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [SCL_W-1:0]    scl_r, scl_nxt;
  logic [MVP_W-1:0]    mvp_r, mvp_nxt;
  logic                va_r, vb_r, vc_r;
  logic                ra, rb, rc;
  logic [SAMPLE_W-1:0] avg;
  mv_t                 mv;

  assign rc = !vc_r || mv_ready;
  assign rb = !vb_r || rc;
  assign ra = !va_r || rb;
  assign tot_ready = ra;

  assign prod_nxt = PROD_W'(tot_sum) * PROD_W'(DIV_M);
  assign avg      = prod_r[DIV_K +: SAMPLE_W];
  assign scl_nxt  = SCL_W'(avg) * SCL_W'(MV_FULL);
  assign mvp_nxt  = MVP_W'(scl_r) * MVP_W'(MV_RECIP);
  assign mv       = mvp_r[MV_SHIFT +: MV_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (ra) va_r <= tot_valid;
      if (rb) vb_r <= va_r;
      if (rc) vc_r <= vb_r;
    end
    if (ra) prod_r <= prod_nxt;
    if (rb) scl_r  <= scl_nxt;
    if (rc) mvp_r  <= mvp_nxt;
  end

  assign mv_valid = vc_r;
  assign mv_value = mv;

`ifndef NO_ASSERTIONS
  a_scl_range: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r |-> scl_r <= SCL_MAX) else $error("scaled average out of range");
  a_mv_range: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r |-> mv <= MV_FULL) else $error("millivolt value out of range");
  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vb_r && !rb) |=> vb_r) else $error("stalled word dropped in conversion");
`endif

endmodule

### rtl/core/lvad_match.sv
// Window compare against the nominal table, priority pick and result register.
// Depends on lvad_pkg.
module lvad_match (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lvad_pkg::WIN_W-1:0]    window_mv,
  input  logic                          mv_valid,
  output logic                          mv_ready,
  input  lvad_pkg::mv_t                 mv_value,
  output logic                          res_valid,
  input  logic                          res_ready,
  output lvad_pkg::result_t             res
);
  import lvad_pkg::*;

  localparam int CMP_W = MV_W + 1;

  logic [NUM_NOM-1:0] hit;
  logic [IDX_W-1:0]   idx;
  result_t            res_r, res_nxt;
  logic               rv_r;

  assign mv_ready = !rv_r || res_ready;

  // |mv - nom| <= w  is  mv <= nom + w  and  nom <= mv + w.
  always_comb begin
    for (int i = 0; i < NUM_NOM; i++) begin
      hit[i] = (CMP_W'(mv_value) <= CMP_W'(NOMINAL_MV[i]) + CMP_W'(window_mv)) &&
               (CMP_W'(NOMINAL_MV[i]) <= CMP_W'(mv_value) + CMP_W'(window_mv));
    end
  end

  always_comb begin
    idx = '0;
    for (int i = NUM_NOM - 1; i >= 0; i--) begin
      if (hit[i]) idx = IDX_W'(i);
    end
  end

  always_comb begin
    res_nxt.found      = |hit;
    res_nxt.address    = (|hit) ? (ADDR_BASE | ADDR_W'(idx)) : '0;
    res_nxt.millivolts = mv_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
    end else if (mv_ready) begin
      rv_r <= mv_valid;
    end
    if (mv_ready) res_r <= res_nxt;
  end

  assign res_valid = rv_r;
  assign res       = res_r;

`ifndef NO_ASSERTIONS
  a_miss_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (rv_r && !res_r.found) |-> res_r.address == '0)
    else $error("address nonzero without a match");
  a_hit_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (rv_r && res_r.found) |-> res_r.address[ADDR_W-1:IDX_W] == ADDR_BASE[ADDR_W-1:IDX_W])
    else $error("matched address outside the strap range");
  a_pick_lowest: assert property (@(posedge clk) disable iff (!rst_n)
    (mv_valid && hit[0]) |-> idx == '0) else $error("priority pick is not the lowest");
`endif

endmodule

### rtl/core/ladder_voltage_address_decoder.sv
// Top level of the ladder voltage address decoder.
// Instantiates lvad_accum, lvad_convert and lvad_match; depends on lvad_pkg.
//
// Usage:
//   in_*   : stream of raw 10-bit converter words, in_tdata[9:0] = sample.
//   out_*  : one result word per batch of SAMPLES input words.
//   cfg_*  : cfg_wr_en writes cfg_wr_data into the window half-width (mV).
//            Write it only while no batch result is still in flight.
// Each batch total is averaged (floored), scaled to millivolts as
// avg*3300/1023 (floored) and compared against sixteen nominal voltages.
// The lowest index inside +/- window gives address 0x30+index.
// Throughput is one input word per cycle while out_tready is high.
// The path runs through five register stages (batch total, two
// reciprocal multiplies, the scale multiply and the result
// register).
// Synchronous reset clears the running sum, the sample count, all stage
// valids, and sets the window to 75 mV.
// When the receiver holds out_tready low, the result word holds and the
// stages behind it keep filling; in_tready drops only once every stage
// holds a pending batch.
module ladder_voltage_address_decoder #(
  parameter int SAMPLES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // [9:0] sample, [15:10] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,    // [0] found, [6:1] address, [18:7] millivolts, rest zero
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data   // window_mv
);
  import lvad_pkg::*;

  localparam int SUM_W = $clog2(1023 * SAMPLES + 1);

  logic [WIN_W-1:0] win_r;
  logic             tot_valid, tot_ready, mv_valid, mv_ready;
  logic [SUM_W-1:0] tot_sum;
  mv_t              mv_value;
  result_t          res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WIN_RESET;
    end else if (cfg_wr_en) begin
      win_r <= cfg_wr_data;
    end
  end

  lvad_accum #(.SAMPLES(SAMPLES), .SUM_W(SUM_W)) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_tdata[SAMPLE_W-1:0]),
    .tot_valid (tot_valid),
    .tot_ready (tot_ready),
    .tot_sum   (tot_sum)
  );

  lvad_convert #(.SAMPLES(SAMPLES), .SUM_W(SUM_W)) u_convert (
    .clk       (clk),
    .rst_n     (rst_n),
    .tot_valid (tot_valid),
    .tot_ready (tot_ready),
    .tot_sum   (tot_sum),
    .mv_valid  (mv_valid),
    .mv_ready  (mv_ready),
    .mv_value  (mv_value)
  );

  lvad_match u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .window_mv (win_r),
    .mv_valid  (mv_valid),
    .mv_ready  (mv_ready),
    .mv_value  (mv_value),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {5'd0, res.millivolts, res.address, res.found};

endmodule
